### rtl/ckb_pkg.sv
// shared types, constants and round functions for the chacha20 keystream block
// no dependencies
package ckb_pkg;

    localparam int unsigned RoundCount = 20;
    localparam int unsigned RoundW     = 5;
    localparam int unsigned ReqW       = 7;
    localparam int unsigned RegIdxW    = 3;
    localparam int unsigned QDepth     = 2;

    localparam logic [63:0] ConstLoReset = 64'h3320646e61707865;
    localparam logic [63:0] ConstHiReset = 64'h6b20657479622d32;

    localparam logic [RegIdxW-1:0] RegConstLo = 3'd0;
    localparam logic [RegIdxW-1:0] RegConstHi = 3'd1;
    localparam logic [RegIdxW-1:0] RegKey01   = 3'd2;
    localparam logic [RegIdxW-1:0] RegKey23   = 3'd3;
    localparam logic [RegIdxW-1:0] RegKey45   = 3'd4;
    localparam logic [RegIdxW-1:0] RegKey67   = 3'd5;
    localparam logic [RegIdxW-1:0] RegCounter = 3'd6;
    localparam logic [RegIdxW-1:0] RegNonce   = 3'd7;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } core_state_t;

    // command from front to back: saturated byte count
    typedef struct packed {
        logic [ReqW-1:0] bytes;
    } cmd_t;

    function automatic word_t rotl(word_t v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [127:0] qround(word_t a, word_t b, word_t c, word_t d);
        word_t a1, b1, c1, d1;
        a1 = a + b;   d1 = rotl(d ^ a1, 16);
        c1 = c + d1;  b1 = rotl(b ^ c1, 12);
        a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
        c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
        return {d1, c1, b1, a1};
    endfunction

endpackage

### rtl/ckb_front.sv
// front end: takes requests, drops empty ones, saturates, queues commands
// depends on ckb_pkg
module ckb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output ckb_pkg::cmd_t     cmd
);
    import ckb_pkg::*;

    cmd_t        q_reg [QDepth];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [6:0]  req;
    logic        push, pop;

    assign req       = s_tdata[6:0];
    assign s_tready  = (cnt_reg != 2'(QDepth));
    assign push      = s_tvalid && s_tready && (req != '0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg].bytes <= (req > 7'd64) ? 7'd64 : req;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

### rtl/ckb_core.sv
// back end: chacha rounds one per cycle, final add and output beats
// depends on ckb_pkg
module ckb_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ckb_pkg::cmd_t     cmd,
    input  ckb_pkg::state_t   init_state,
    output logic              blk_done,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic [3:0]        m_tuser,
    output logic              m_tlast
);
    import ckb_pkg::*;

    core_state_t st_reg, st_next;
    state_t      w_reg, w_next, init_reg;
    logic [RoundW-1:0] rnd_reg, rnd_next;
    logic [6:0]  rem_reg, rem_next;
    logic [2:0]  k_reg, k_next;
    logic [63:0] word;
    logic [127:0] q0, q1, q2, q3;
    logic        beat;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:  if (cmd_valid) st_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == RoundW'(RoundCount - 1)) st_next = ST_ADD;
            ST_ADD:   st_next = ST_EMIT;
            ST_EMIT:  if (m_tready && rem_reg <= 7'd8) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (!rnd_reg[0]) begin
            q0 = qround(w_reg[0], w_reg[4], w_reg[8],  w_reg[12]);
            q1 = qround(w_reg[1], w_reg[5], w_reg[9],  w_reg[13]);
            q2 = qround(w_reg[2], w_reg[6], w_reg[10], w_reg[14]);
            q3 = qround(w_reg[3], w_reg[7], w_reg[11], w_reg[15]);
        end else begin
            q0 = qround(w_reg[0], w_reg[5], w_reg[10], w_reg[15]);
            q1 = qround(w_reg[1], w_reg[6], w_reg[11], w_reg[12]);
            q2 = qround(w_reg[2], w_reg[7], w_reg[8],  w_reg[13]);
            q3 = qround(w_reg[3], w_reg[4], w_reg[9],  w_reg[14]);
        end
    end

    always_comb begin
        cmd_ready = (st_reg == ST_IDLE);
        m_tvalid  = (st_reg == ST_EMIT);
        beat      = m_tvalid && m_tready;
        blk_done  = beat && (rem_reg <= 7'd8);
        word      = {w_reg[{k_reg, 1'b1}], w_reg[{k_reg, 1'b0}]};
        m_tlast   = (rem_reg <= 7'd8);
        m_tuser   = m_tlast ? rem_reg[3:0] : 4'd8;
        m_tdata   = word;
        if (m_tlast && rem_reg[3:0] != 4'd8) begin
            m_tdata = word & ((64'd1 << {rem_reg[2:0], 3'b000}) - 64'd1);
        end
    end

    always_comb begin
        w_next   = w_reg;
        rnd_next = rnd_reg;
        rem_next = rem_reg;
        k_next   = k_reg;
        case (st_reg)
            ST_IDLE: begin
                w_next   = init_state;
                rnd_next = '0;
                rem_next = cmd.bytes;
                k_next   = '0;
            end
            ST_ROUND: begin
                rnd_next = rnd_reg + 1'b1;
                if (!rnd_reg[0]) begin
                    {w_next[12], w_next[8],  w_next[4], w_next[0]} = q0;
                    {w_next[13], w_next[9],  w_next[5], w_next[1]} = q1;
                    {w_next[14], w_next[10], w_next[6], w_next[2]} = q2;
                    {w_next[15], w_next[11], w_next[7], w_next[3]} = q3;
                end else begin
                    {w_next[15], w_next[10], w_next[5], w_next[0]} = q0;
                    {w_next[12], w_next[11], w_next[6], w_next[1]} = q1;
                    {w_next[13], w_next[8],  w_next[7], w_next[2]} = q2;
                    {w_next[14], w_next[9],  w_next[4], w_next[3]} = q3;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 16; i++) w_next[i] = w_reg[i] + init_reg[i];
            end
            ST_EMIT: begin
                if (beat) begin
                    rem_next = rem_reg - 7'd8;
                    k_next   = k_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        rnd_reg <= rnd_next;
        rem_reg <= rem_next;
        k_reg   <= k_next;
        if (st_reg == ST_IDLE) init_reg <= init_state;
        if (!aresetn) st_reg <= ST_IDLE;
        else          st_reg <= st_next;
    end
endmodule

### rtl/chacha20_keystream_block.sv
// chacha20 keystream block generator, top level with config registers
// a request runs 20 rounds one per cycle, then the final add, then output beats
// core takes a request only after the last beat of a block; rounds are the limit
// a two-entry command queue lets requests be taken while a block is in work
// reset: aresetn synchronous active low; constants to standard values, others zero
// depends on ckb_pkg, ckb_front, ckb_core
module chacha20_keystream_block (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // block_bytes [6:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // keystream_word [63:0]
    output logic [3:0]  m_tuser,   // valid_bytes [3:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);
    import ckb_pkg::*;

    logic [63:0] regs_reg [8];
    word_t       ctr_reg;
    state_t      init_state;
    cmd_t        cmd;
    logic        cmd_valid, cmd_ready, blk_done;

    // state words from registers, word 12 from the running counter
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            init_state[2*i]   = regs_reg[i][31:0];
            init_state[2*i+1] = regs_reg[i][63:32];
        end
        init_state[12] = ctr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[RegConstLo] <= ConstLoReset;
            regs_reg[RegConstHi] <= ConstHiReset;
            regs_reg[RegKey01]   <= '0;
            regs_reg[RegKey23]   <= '0;
            regs_reg[RegKey45]   <= '0;
            regs_reg[RegKey67]   <= '0;
            regs_reg[RegCounter] <= '0;
            regs_reg[RegNonce]   <= '0;
            ctr_reg              <= '0;
        end else begin
            if (cfg_we) regs_reg[cfg_addr] <= cfg_wdata;
            // counter load from config, else advance once per finished block
            if (cfg_we && cfg_addr == RegCounter) ctr_reg <= cfg_wdata[31:0];
            else if (blk_done)                     ctr_reg <= ctr_reg + 32'd1;
        end
    end

    ckb_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .cmd_valid, .cmd_ready, .cmd
    );

    ckb_core u_core (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd, .init_state,
        .blk_done, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );
endmodule

### bench/tb.sv
// self-checking bench for chacha20_keystream_block: streams byte-count requests and checks
// each 64-bit keystream word, valid_bytes and last against a behavioral chacha20 block model in this file
// depends on ckb_pkg and the rtl top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ckb_pkg::*;

    localparam int WatchdogLimit = 3000;
    localparam int SettleCycles  = 40;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } ks_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = 3'd0;
    logic [63:0] cfg_wdata = 64'd0;

    // byte-count requests waiting to go out, and keystream words still owed by the block
    logic [6:0] pending_reqs[$];
    ks_beat_t   owed_beats[$];

    // model copy of the register file and the running block counter
    logic [63:0] model_regs[8];
    logic [31:0] model_ctr;

    int  errors      = 0;
    int  req_count   = 0;
    int  beat_count  = 0;
    int  zero_reqs   = 0;
    int  quiet_count = 0;
    bit  no_idle     = 0;
    int  send_gap    = 0;
    int  recv_stall  = 0;

    chacha20_keystream_block uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // block_bytes [6:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // keystream_word [63:0]
        .m_tuser  (m_tuser),    // valid_bytes [3:0]
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] rot_left(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // one chacha quarter round on four words of the working state
    function automatic void mix_quarter(ref logic [31:0] w[16], input int a, int b, int c,
                                        int d);
        w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
    endfunction

    // works out the keystream words for one request and advances the counter, except for zero requests
    function automatic void predict_keystream(logic [6:0] req);
        logic [31:0] init[16];
        logic [31:0] w[16];
        logic [63:0] word;
        int n;
        int beats;
        int vb;
        n = req;
        if (n == 0) begin
            zero_reqs++;
            return;
        end
        if (n > 64) n = 64;   // oversized requests clip to one full block
        for (int i = 0; i < 8; i++) begin
            init[2*i]   = model_regs[i][31:0];
            init[2*i+1] = model_regs[i][63:32];
        end
        init[12] = model_ctr;
        w = init;
        for (int r = 0; r < RoundCount; r++) begin
            if (r % 2 == 0) begin
                mix_quarter(w, 0, 4, 8, 12);
                mix_quarter(w, 1, 5, 9, 13);
                mix_quarter(w, 2, 6, 10, 14);
                mix_quarter(w, 3, 7, 11, 15);
            end else begin
                mix_quarter(w, 0, 5, 10, 15);
                mix_quarter(w, 1, 6, 11, 12);
                mix_quarter(w, 2, 7, 8, 13);
                mix_quarter(w, 3, 4, 9, 14);
            end
        end
        for (int i = 0; i < 16; i++) w[i] = w[i] + init[i];
        beats = (n + 7) / 8;
        for (int k = 0; k < beats; k++) begin
            word = {w[2*k+1], w[2*k]};
            vb = (n - 8*k > 8) ? 8 : n - 8*k;
            // bytes past the requested count read as zero
            if (vb < 8) word = word & ((64'd1 << (8*vb)) - 64'd1);
            owed_beats.push_back('{word, 4'(vb), k == beats - 1});
        end
        model_ctr = model_ctr + 32'd1;   // wraps mod 2^32, word 13 untouched
    endfunction

    // request driver: random gap after each item, none during no_idle stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_keystream(s_tdata[6:0]);
                req_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_tdata  <= {1'b0, pending_reqs.pop_front()};
                    s_tvalid <= 1'b1;
                    send_gap <= no_idle ? 0 : $urandom_range(0, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each accepted word with the oldest owed one
    always @(posedge aclk) begin
        ks_beat_t exp_beat;
        int       gap;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                beat_count++;
                if (owed_beats.size() == 0) begin
                    $error("unexpected keystream word %h", m_tdata);
                    errors++;
                end else begin
                    exp_beat = owed_beats.pop_front();
                    if (m_tdata !== exp_beat.word) begin
                        $error("keystream_word expected %h got %h", exp_beat.word, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== exp_beat.nbytes) begin
                        $error("valid_bytes expected %0d got %0d", exp_beat.nbytes, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== exp_beat.last) begin
                        $error("last expected %0b got %0b", exp_beat.last, m_tlast);
                        errors++;
                    end
                end
                gap        = no_idle ? 0 : $urandom_range(0, 9);
                recv_stall <= gap;
                m_tready   <= (gap == 0);
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= (recv_stall == 1);
            end else begin
                m_tready   <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WatchdogLimit) begin
            $display("timeout after %0d quiet cycles", quiet_count);
            $display("FAIL chacha20_keystream_block");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // write one register while the block is idle and mirror it in the model
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        model_regs[idx] = val;
        if (idx == RegCounter) model_ctr = val[31:0];   // low half reloads the counter
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // waits until every request is sent and every owed word has arrived, then lets a zero request settle
    task automatic drain();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_reqs.size() > 0 || s_tvalid || owed_beats.size() > 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    function automatic logic [6:0] random_req();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 16) return 7'($urandom_range(1, 64));
        if (pick < 18) return 7'($urandom_range(65, 127));
        return 7'd0;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [6:0] directed[$];
        model_regs[RegConstLo] = ConstLoReset;
        model_regs[RegConstHi] = ConstHiReset;
        for (int i = 2; i < 8; i++) model_regs[i] = 64'd0;
        model_ctr = 32'd0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        #1;

        // directed: edges of the byte count, zero requests, oversize saturation
        directed = '{7'd1, 7'd7, 7'd8, 7'd9, 7'd15, 7'd16, 7'd17, 7'd0, 7'd63, 7'd64,
                     7'd65, 7'd127, 7'd0, 7'd32, 7'd33, 7'd56, 7'd57, 7'd2, 7'd96};
        pending_reqs = directed;
        drain();

        // all-ones state with the counter just below wrap
        for (int i = 0; i < 8; i++) begin
            write_reg(3'(i), (i == RegCounter) ? 64'hFFFF_FFFF_FFFF_FFFE : 64'hFFFF_FFFF_FFFF_FFFF);
        end
        end_writes();
        #1;
        pending_reqs = '{7'd64, 7'd5, 7'd0, 7'd64, 7'd127};
        drain();

        // all-zero state, including the constants
        for (int i = 0; i < 8; i++) write_reg(3'(i), 64'd0);
        end_writes();
        #1;
        pending_reqs = '{7'd64, 7'd1, 7'd40};
        drain();

        // random phases with fresh constants, keys, nonces and counters
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 8; i++) begin
                if (ph == 0 || $urandom_range(0, 1)) begin
                    if (i == RegCounter && $urandom_range(0, 1))
                        write_reg(3'(i), {$urandom(), 32'hFFFF_FFFF - $urandom_range(0, 3)});
                    else
                        write_reg(3'(i), rand64());
                end
            end
            end_writes();
            no_idle = (ph == 2);
            #1;
            for (int k = 0; k < 50; k++) pending_reqs.push_back(random_req());
            drain();
        end

        $display("covered %0d requests (%0d of zero length) and %0d keystream words",
                 req_count, zero_reqs, beat_count);
        $display("register settings: reset, all ones, all zeros, six random sets");
        if (errors == 0 && owed_beats.size() == 0) begin
            $display("PASS chacha20_keystream_block");
        end else begin
            $display("FAIL chacha20_keystream_block");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ckb_pkg.sv
rtl/ckb_front.sv
rtl/ckb_core.sv
rtl/chacha20_keystream_block.sv
bench/tb.sv
